// ===== src/gbba_pkg.sv =====
`default_nettype none
package gbba_pkg;
  localparam int BlocksPerGroup = 1024;
  localparam int MaxGroups = 16;
  localparam int WordW = 32;
  localparam int WordsPerGroup = BlocksPerGroup / WordW;
  localparam int TotalWords = WordsPerGroup * MaxGroups;
  localparam int AddrW = $clog2(TotalWords);
  localparam int WselW = $clog2(WordsPerGroup);
  localparam int BitW = $clog2(WordW);
  localparam int GrpW = $clog2(MaxGroups);
  localparam int CntW = $clog2(BlocksPerGroup) + 1;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StRange = 2'd2;
  localparam logic [1:0] StFree = 2'd3;

  localparam logic RegGroupCount = 1'b0;
  localparam logic RegFirstData = 1'b1;

  typedef struct packed {
    logic        func;
    logic [3:0]  prefer_group;
    logic [14:0] block_num;
  } req_t;

  typedef struct packed {
    logic [14:0] alloc_block;
    logic [1:0]  status;
    logic [14:0] used_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MOD, S_GRP, S_RD, S_CHK, S_WR, S_DONE
  } state_e;
endpackage
`default_nettype wire

// ===== src/grouped_bitmap_block_allocator.sv =====
`default_nettype none
// Channel  | Direction | Signals
// request  | in        | start_i, busy_o, req_i
// result   | out       | rsp_valid_o, rsp_o (one-cycle strobe)
// config   | in        | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
// After reset a clearing pass sweeps the 512-word bitmap memory, one word a
// cycle with busy high. Free: read the word, check the bit, write it back,
// then done; out of range goes straight to done, an already free block skips
// the write. Allocate: reduce prefer_group modulo the group count (one
// subtract a cycle), try the groups in turn, scan 32-bit bitmap words for a
// clear bit, then write and done. The single memory read port sets the pace.
// The receiver cannot stall; results are strobed once.
module grouped_bitmap_block_allocator (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  output logic                busy_o,
  input  gbba_pkg::req_t      req_i,
  output logic                rsp_valid_o,
  output gbba_pkg::rsp_t      rsp_o,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire                 cfg_index_i,
  input  wire  [4:0]          cfg_data_i
);
  import gbba_pkg::*;

  logic [WordW-1:0] mem_q [TotalWords];
  logic [WordW-1:0] rdata_q;
  logic [AddrW-1:0] addr;
  logic             we;
  logic [WordW-1:0] wdata;

  state_e state_q, state_d;
  logic [4:0] gcnt_q;
  logic       fdb_q;
  logic [CntW-1:0] gused_q [MaxGroups];
  logic [14:0] total_q, total_d;
  logic [GrpW-1:0] grp_q, grp_d;
  logic [4:0]  tried_q, tried_d;
  logic [WselW-1:0] wsel_q, wsel_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic        func_q, func_d;
  logic [BitW-1:0] bit_q, bit_d;
  rsp_t        rsp_q, rsp_d;
  logic        rv_q, rv_d;
  logic        ginc, gdec;

  logic [4:0] nact;
  always_comb begin
    nact = gcnt_q;
    if (gcnt_q == 5'd0) nact = 5'd1;
    if (gcnt_q > 5'(MaxGroups)) nact = 5'(MaxGroups);
  end

  // first clear bit of the read word
  logic            fz_found;
  logic [BitW-1:0] fz_idx;
  always_comb begin
    fz_found = 1'b0;
    fz_idx = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (!rdata_q[i]) begin
        fz_found = 1'b1;
        fz_idx = BitW'(i);
      end
    end
  end

  // free decode
  logic [14:0] off;
  logic        below;
  logic [4:0]  fgrp;
  assign below = req_i.block_num < 15'(fdb_q);
  assign off   = req_i.block_num - 15'(fdb_q);
  assign fgrp  = 5'(off >> $clog2(BlocksPerGroup));

  logic [GrpW-1:0] grp_nx;
  always_comb begin
    grp_nx = grp_q + 1'b1;
    if (5'(grp_q) + 5'd1 >= nact) grp_nx = '0;
  end

  always_comb begin
    state_d = state_q;
    total_d = total_q;
    grp_d = grp_q;
    tried_d = tried_q;
    wsel_d = wsel_q;
    clr_d = clr_q;
    func_d = func_q;
    bit_d = bit_q;
    rsp_d = rsp_q;
    rv_d = 1'b0;
    ginc = 1'b0;
    gdec = 1'b0;
    we = 1'b0;
    wdata = '0;
    addr = {grp_q, wsel_q};
    unique case (state_q)
      S_CLEAR: begin
        addr = clr_q;
        we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(TotalWords - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          func_d = req_i.func;
          rsp_d.alloc_block = '0;
          if (!req_i.func) begin
            grp_d = req_i.prefer_group;
            tried_d = '0;
            state_d = S_MOD;
          end else if (below || fgrp >= nact) begin
            rsp_d.status = StRange;
            state_d = S_DONE;
          end else begin
            grp_d = fgrp[GrpW-1:0];
            wsel_d = off[BitW +: WselW];
            bit_d = off[BitW-1:0];
            state_d = S_RD;
          end
        end
      end
      // start group modulo the active count by repeated subtraction
      S_MOD: begin
        if (5'(grp_q) >= nact) grp_d = grp_q - nact[GrpW-1:0];
        else state_d = S_GRP;
      end
      S_GRP: begin
        if (tried_q >= nact) begin
          rsp_d.status = StFull;
          state_d = S_DONE;
        end else if (gused_q[grp_q] >= CntW'(BlocksPerGroup)) begin
          grp_d = grp_nx;
          tried_d = tried_q + 1'b1;
        end else begin
          wsel_d = '0;
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_CHK;
      S_CHK: begin
        if (func_q) begin
          if (!rdata_q[bit_q]) begin
            rsp_d.status = StFree;
            state_d = S_DONE;
          end else state_d = S_WR;
        end else if (fz_found) begin
          bit_d = fz_idx;
          state_d = S_WR;
        end else begin
          wsel_d = wsel_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_WR: begin
        we = 1'b1;
        wdata = rdata_q;
        wdata[bit_q] = !func_q;
        rsp_d.status = StOk;
        if (func_q) begin
          gdec = 1'b1;
          if (total_q != '0) total_d = total_q - 1'b1;
        end else begin
          ginc = 1'b1;
          total_d = total_q + 1'b1;
          rsp_d.alloc_block = 15'({grp_q, wsel_q, bit_q}) + 15'(fdb_q);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        rsp_d.used_count = total_q;
        rv_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[addr] <= wdata;
    rdata_q <= mem_q[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      gcnt_q <= 5'd16;
      fdb_q <= 1'b1;
      total_q <= '0;
      clr_q <= '0;
      rv_q <= 1'b0;
      for (int i = 0; i < MaxGroups; i++) gused_q[i] <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      clr_q <= clr_d;
      rv_q <= rv_d;
      if (ginc) gused_q[grp_q] <= gused_q[grp_q] + 1'b1;
      if (gdec && gused_q[grp_q] != '0) gused_q[grp_q] <= gused_q[grp_q] - 1'b1;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegGroupCount: gcnt_q <= cfg_data_i;
          RegFirstData:  fdb_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    tried_q <= tried_d;
    wsel_q <= wsel_d;
    func_q <= func_d;
    bit_q <= bit_d;
    rsp_q <= rsp_d;
  end

  assign busy_o = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign rsp_valid_o = rv_q;
  assign rsp_o = rsp_q;

  a_strobe_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o) else $error("result strobe repeated");
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status != StOk) |-> rsp_o.alloc_block == '0)
    else $error("block number on failed request");
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR && !func_q) |=> total_q == $past(total_q) + 1'b1)
    else $error("used count not bumped");
endmodule
`default_nettype wire

// ===== bench/grouped_bitmap_block_allocator_tb.sv =====
`timescale 1ns / 100ps
module grouped_bitmap_block_allocator_tb;
  import gbba_pkg::*;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree = 1'b1;
  localparam int TotalBlocks = BlocksPerGroup * MaxGroups;
  localparam int CycleLimit = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [4:0] cfg_data_i = '0;
  logic busy_o, rsp_valid_o, cfg_ready_o;
  rsp_t rsp_o;

  grouped_bitmap_block_allocator dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .rsp_valid_o, .rsp_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // allocator shadow state
  bit      used_map [TotalBlocks];
  int      grp_used [MaxGroups];
  int      blocks_in_use;
  int      grp_count_reg;
  int      first_blk_reg;
  int      live_blocks [$];
  rsp_t    pending_rsp [$];
  int      errors;
  int      cycles;
  int      idle_pct;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t e;
  } dir_row_t;

  function automatic int active_groups();
    if (grp_count_reg < 1) return 1;
    if (grp_count_reg > MaxGroups) return MaxGroups;
    return grp_count_reg;
  endfunction

  task automatic predict_request(input req_t r, output rsp_t o);
    int n, g, off, idx;
    bit done;
    n = active_groups();
    o = '0;
    done = 1'b0;
    if (r.func == FuncAlloc) begin
      o.status = StFull;
      for (int k = 0; k < n && !done; k++) begin
        g = (int'(r.prefer_group) + k) % n;
        if (grp_used[g] < BlocksPerGroup) begin
          for (int i = 0; i < BlocksPerGroup && !done; i++) begin
            idx = g * BlocksPerGroup + i;
            if (!used_map[idx]) begin
              used_map[idx] = 1'b1;
              grp_used[g]++;
              blocks_in_use++;
              o.status = StOk;
              o.alloc_block = 15'(g * BlocksPerGroup + first_blk_reg + i);
              live_blocks.push_back(int'(o.alloc_block));
              done = 1'b1;
            end
          end
        end
      end
    end else begin
      off = int'(r.block_num) - first_blk_reg;
      g = off / BlocksPerGroup;
      if (off < 0 || g >= n) begin
        o.status = StRange;
      end else begin
        idx = g * BlocksPerGroup + off % BlocksPerGroup;
        if (!used_map[idx]) begin
          o.status = StFree;
        end else begin
          used_map[idx] = 1'b0;
          if (grp_used[g] > 0) grp_used[g]--;
          if (blocks_in_use > 0) blocks_in_use--;
          o.status = StOk;
        end
      end
    end
    o.used_count = 15'(blocks_in_use);
  endtask

  // called right after a rising edge; returns right after the accepting edge or after a random idle gap
  task automatic issue_request(input req_t r, input bit typed, input rsp_t e);
    rsp_t p;
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
    predict_request(r, p);
    pending_rsp.push_back(typed ? e : p);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0 || busy_o) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegGroupCount) grp_count_reg = int'(val);
    else first_blk_reg = int'(val[0]);
  endtask

  task automatic random_request();
    req_t r;
    int pick;
    r = '0;
    r.prefer_group = 4'($urandom);
    if ($urandom_range(99) < 50) begin
      r.func = FuncAlloc;
      r.block_num = 15'($urandom);
    end else begin
      r.func = FuncFree;
      if (live_blocks.size() != 0 && $urandom_range(99) < 75) begin
        pick = $urandom_range(live_blocks.size() - 1);
        r.block_num = 15'(live_blocks[pick]);
        live_blocks.delete(pick);
      end else if ($urandom_range(1)) begin
        r.block_num = 15'($urandom);
      end else begin
        r.block_num = 15'($urandom_range(TotalBlocks));
      end
    end
    issue_request(r, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    rsp_t x;
    if (rst_ni && rsp_valid_o) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result alloc_block=%0d status=%0d used_count=%0d",
                 $time, rsp_o.alloc_block, rsp_o.status, rsp_o.used_count);
        errors++;
      end else begin
        x = pending_rsp.pop_front();
        if (rsp_o.alloc_block !== x.alloc_block) begin
          $display("%0t: alloc_block expected %0d actual %0d",
                   $time, x.alloc_block, rsp_o.alloc_block);
          errors++;
        end
        if (rsp_o.status !== x.status) begin
          $display("%0t: status expected %0d actual %0d", $time, x.status, rsp_o.status);
          errors++;
        end
        if (rsp_o.used_count !== x.used_count) begin
          $display("%0t: used_count expected %0d actual %0d",
                   $time, x.used_count, rsp_o.used_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic dir_row_t mk(input logic f, input int pg, input int bn, input bit t,
                                  input int ab, input logic [1:0] st, input int uc);
    dir_row_t d;
    d.r.func = f;
    d.r.prefer_group = 4'(pg);
    d.r.block_num = 15'(bn);
    d.typed = t;
    d.e.alloc_block = 15'(ab);
    d.e.status = st;
    d.e.used_count = 15'(uc);
    return d;
  endfunction

  dir_row_t dir_rows [$];
  int grp_plan [5] = '{16, 0, 3, 31, 16};
  int fdb_plan [5] = '{1, 0, 1, 0, 0};

  initial begin
    errors = 0;
    cycles = 0;
    idle_pct = 14;
    blocks_in_use = 0;
    grp_count_reg = 16;
    first_blk_reg = 1;
    foreach (grp_used[g]) grp_used[g] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset state, extremes, the range and already-free error codes
    dir_rows.push_back(mk(FuncAlloc, 0, 0, 1, 1, StOk, 1));
    dir_rows.push_back(mk(FuncAlloc, 15, 32767, 1, 15361, StOk, 2));
    dir_rows.push_back(mk(FuncFree, 0, 0, 1, 0, StRange, 2));
    dir_rows.push_back(mk(FuncFree, 0, 32767, 1, 0, StRange, 2));
    dir_rows.push_back(mk(FuncFree, 0, 5, 1, 0, StFree, 2));
    dir_rows.push_back(mk(FuncFree, 15, 1, 1, 0, StOk, 1));
    dir_rows.push_back(mk(FuncFree, 0, 15361, 1, 0, StOk, 0));
    dir_rows.push_back(mk(FuncAlloc, 7, 0, 0, 0, StOk, 0));
    dir_rows.push_back(mk(FuncAlloc, 7, 0, 0, 0, StOk, 0));
    dir_rows.push_back(mk(FuncAlloc, 8, 21845, 0, 0, StOk, 0));
    dir_rows.push_back(mk(FuncFree, 0, 16384, 0, 0, StOk, 0));
    dir_rows.push_back(mk(FuncFree, 0, 7169, 0, 0, StOk, 0));
    dir_rows.push_back(mk(FuncFree, 0, 7169, 0, 0, StOk, 0));
    dir_rows.push_back(mk(FuncAlloc, 7, 0, 0, 0, StOk, 0));
    @(posedge clk_i);
    foreach (dir_rows[i]) issue_request(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].e);

    foreach (grp_plan[p]) begin
      idle_pct = (p < 2) ? 14 : (p < 4) ? 61 : 0;
      write_reg(RegGroupCount, 5'(grp_plan[p]));
      write_reg(RegFirstData, 5'(fdb_plan[p]));
      @(posedge clk_i);
      // prefer beyond the count and frees past the last group
      if (p == 2) begin
        issue_request(mk(FuncAlloc, 15, 0, 0, 0, StOk, 0).r, 1'b0, '0);
        issue_request(mk(FuncFree, 0, 15361, 0, 0, StOk, 0).r, 1'b0, '0);
      end
      repeat (108) random_request();
    end

    // single group
    idle_pct = 14;
    write_reg(RegGroupCount, 5'd1);
    write_reg(RegFirstData, 5'd1);
    @(posedge clk_i);
    repeat (40) random_request();

    start_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
